// File: rtl/tci_pkg.sv
// ----------------------------------------------------------------------------
// Transport command interlock package
// Transaction types, command and status codes, register indexes and
// reset values shared by the interlock modules.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_WIN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_TIMEOUT = 2'd3;

    // Register reset values, before clamping to the timer range
    localparam logic [CFG_DATA_W-1:0] PRESS_RST        = 16'd200;
    localparam logic [CFG_DATA_W-1:0] MOTION_WIN_RST   = 16'd400;
    localparam logic [CFG_DATA_W-1:0] SETTLE_RST       = 16'd500;
    localparam logic [CFG_DATA_W-1:0] STOP_TIMEOUT_RST = 16'd8000;

    // Command codes
    localparam logic [2:0] CMD_STOP   = 3'd0;
    localparam logic [2:0] CMD_FF     = 3'd1;
    localparam logic [2:0] CMD_REW    = 3'd2;
    localparam logic [2:0] CMD_PLAY   = 3'd3;
    localparam logic [2:0] CMD_RECORD = 3'd4;
    localparam logic [2:0] CMD_ARM    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_NOT_ARMED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd_code;
        logic       motion_edge;
        logic       record_armed;
    } in_item_t;

    typedef struct packed {
        logic       stop_contact;
        logic       play_contact;
        logic       ff_contact;
        logic       rewind_contact;
        logic       record_contact;
        logic       busy_res;
        logic [2:0] cmd_status;
        logic       consume_arm;
        logic       reels_turning;
    } out_item_t;

endpackage

// File: rtl/tci_cfg.sv
// ----------------------------------------------------------------------------
// Transport command interlock configuration registers
// Holds the four timing registers, clamping written values to the timer range.
// ----------------------------------------------------------------------------
module tci_cfg #(
    parameter int TIMER_WIDTH = tci_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tci_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tci_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [TIMER_WIDTH-1:0]           press_ticks,
    output logic [TIMER_WIDTH-1:0]           motion_window_ticks,
    output logic [TIMER_WIDTH-1:0]           settle_ticks,
    output logic [TIMER_WIDTH-1:0]           stop_timeout_ticks
);
    import tci_pkg::*;

    localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

    // Saturate a register value at the top of the timer range
    function automatic logic [TIMER_WIDTH-1:0] clamp(input logic [CFG_DATA_W-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        if (33'(v) > TMAX) begin
            r = '1;
        end else begin
            r = TIMER_WIDTH'(v);
        end
        return r;
    endfunction

    logic [TIMER_WIDTH-1:0] press_reg;
    logic [TIMER_WIDTH-1:0] motion_win_reg;
    logic [TIMER_WIDTH-1:0] settle_reg;
    logic [TIMER_WIDTH-1:0] stop_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg        <= clamp(PRESS_RST);
            motion_win_reg   <= clamp(MOTION_WIN_RST);
            settle_reg       <= clamp(SETTLE_RST);
            stop_timeout_reg <= clamp(STOP_TIMEOUT_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PRESS:        press_reg        <= clamp(cfg_wdata);
                REG_MOTION_WIN:   motion_win_reg   <= clamp(cfg_wdata);
                REG_SETTLE:       settle_reg       <= clamp(cfg_wdata);
                REG_STOP_TIMEOUT: stop_timeout_reg <= clamp(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign press_ticks         = press_reg;
    assign motion_window_ticks = motion_win_reg;
    assign settle_ticks        = settle_reg;
    assign stop_timeout_ticks  = stop_timeout_reg;

endmodule

// File: rtl/tci_core.sv
// ----------------------------------------------------------------------------
// Transport command interlock sequencer core
// Motion counter, command sequencer state and the per-tick result logic.
// ----------------------------------------------------------------------------
module tci_core #(
    parameter int TIMER_WIDTH = tci_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  tci_pkg::in_item_t      item,
    input  logic [TIMER_WIDTH-1:0] press_ticks,
    input  logic [TIMER_WIDTH-1:0] motion_window_ticks,
    input  logic [TIMER_WIDTH-1:0] settle_ticks,
    input  logic [TIMER_WIDTH-1:0] stop_timeout_ticks,
    output tci_pkg::out_item_t     result
);
    import tci_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_PRESS      = 6'b000010,
        PH_STOP_PRESS = 6'b000100,
        PH_WAIT_STOP  = 6'b001000,
        PH_SETTLE     = 6'b010000,
        PH_FINAL      = 6'b100000
    } phase_t;

    // Contact mask bits
    localparam int C_STOP = 0;
    localparam int C_PLAY = 1;
    localparam int C_FF   = 2;
    localparam int C_REW  = 3;
    localparam int C_REC  = 4;

    localparam logic [TIMER_WIDTH-1:0] TMR_ONE = TIMER_WIDTH'(1);

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] motion_reg, motion_next;
    logic [4:0]             target_reg, target_next;
    logic                   rec_seq_reg, rec_seq_next;

    logic       moving;
    logic [4:0] contacts;
    logic [2:0] status;
    logic       busy;
    logic       consume;

    always_comb begin
        // Motion counter saturates at the top of the timer range
        if (item.motion_edge) begin
            motion_next = '0;
        end else if (motion_reg != '1) begin
            motion_next = motion_reg + TMR_ONE;
        end else begin
            motion_next = motion_reg;
        end
        moving = motion_next < motion_window_ticks;

        phase_next   = phase_reg;
        timer_next   = timer_reg;
        target_next  = target_reg;
        rec_seq_next = rec_seq_reg;
        contacts     = '0;
        status       = ST_NONE;
        busy         = 1'b0;
        consume      = 1'b0;

        // Command intake
        if (phase_reg != PH_IDLE) begin
            busy = 1'b1;
            if (item.cmd_valid) begin
                status = ST_BUSY;
            end
        end else if (item.cmd_valid) begin
            if (item.cmd_code inside {CMD_STOP, CMD_FF, CMD_REW}) begin
                target_next = '0;
                case (item.cmd_code)
                    CMD_STOP: target_next[C_STOP] = 1'b1;
                    CMD_FF:   target_next[C_FF]   = 1'b1;
                    default:  target_next[C_REW]  = 1'b1;
                endcase
                rec_seq_next = 1'b0;
                phase_next   = PH_PRESS;
                timer_next   = press_ticks;
                busy         = 1'b1;
            end else if (item.cmd_code inside {CMD_PLAY, CMD_RECORD}) begin
                if (item.cmd_code == CMD_RECORD && !item.record_armed) begin
                    status = ST_NOT_ARMED;
                end else begin
                    rec_seq_next         = (item.cmd_code == CMD_RECORD);
                    target_next          = '0;
                    target_next[C_PLAY]  = 1'b1;
                    target_next[C_REC]   = (item.cmd_code == CMD_RECORD);
                    if (moving) begin
                        phase_next = PH_STOP_PRESS;
                        timer_next = press_ticks;
                    end else begin
                        phase_next = PH_WAIT_STOP;
                        timer_next = '0;
                    end
                    busy = 1'b1;
                end
            end else if (item.cmd_code == CMD_ARM) begin
                status = ST_OK;
            end else begin
                status = ST_UNKNOWN;
            end
        end

        // Sequence advance, including a phase entered this tick
        case (phase_next)
            PH_PRESS: begin
                contacts = target_next;
                if (timer_next <= TMR_ONE) begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    status     = ST_OK;
                end else begin
                    timer_next = timer_next - TMR_ONE;
                end
            end
            PH_STOP_PRESS: begin
                contacts[C_STOP] = 1'b1;
                if (timer_next <= TMR_ONE) begin
                    phase_next = PH_WAIT_STOP;
                    timer_next = '0;
                end else begin
                    timer_next = timer_next - TMR_ONE;
                end
            end
            PH_WAIT_STOP: begin
                if (!moving) begin
                    phase_next = PH_SETTLE;
                    timer_next = settle_ticks;
                end else if (timer_next >= stop_timeout_ticks) begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                    status     = ST_TIMEOUT;
                end else begin
                    timer_next = timer_next + TMR_ONE;
                end
            end
            PH_SETTLE: begin
                if (timer_next != '0) begin
                    timer_next = timer_next - TMR_ONE;
                end else begin
                    phase_next = PH_FINAL;
                    timer_next = press_ticks;
                end
            end
            default: ;
        endcase

        // The final press may start on the tick that settling ends
        if (phase_next == PH_FINAL) begin
            contacts = target_next;
            if (timer_next <= TMR_ONE) begin
                phase_next = PH_IDLE;
                timer_next = '0;
                status     = ST_OK;
                consume    = rec_seq_next;
            end else begin
                timer_next = timer_next - TMR_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            motion_reg  <= '0;
            target_reg  <= '0;
            rec_seq_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            motion_reg  <= motion_next;
            target_reg  <= target_next;
            rec_seq_reg <= rec_seq_next;
        end
    end

    always_comb begin
        result.stop_contact   = contacts[C_STOP];
        result.play_contact   = contacts[C_PLAY];
        result.ff_contact     = contacts[C_FF];
        result.rewind_contact = contacts[C_REW];
        result.record_contact = contacts[C_REC];
        result.busy_res       = busy;
        result.cmd_status     = status;
        result.consume_arm    = consume;
        result.reels_turning  = moving;
    end

endmodule

// File: rtl/transport_command_interlock.sv
// ----------------------------------------------------------------------------
// Transport command interlock
// Tick-driven remote-contact sequencer for a tape transport: one input
// transaction per tick, one result transaction per tick.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Direction  Transaction
//  s_        s_valid / s_ready / s_data          in         one tick: command, edge
//  m_        m_valid / m_ready / m_data          out        one tick: contacts, status
//  cfg_      cfg_wr_en / cfg_index / cfg_wdata   in         register write, no wait
//
//  A transaction is captured in the input register, stepped through the
//  sequencer and lands in the result register; one transaction per cycle is
//  sustained while m_ready stays high.
//  Synchronous active-low reset puts the sequencer idle, reels counted as moving.
//  A stalled result holds the result register; the input register takes a
//  further transaction only once its own contents move on.
// ----------------------------------------------------------------------------
module transport_command_interlock #(
    parameter int TIMER_WIDTH = tci_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tci_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tci_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [tci_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tci_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import tci_pkg::*;

    logic                   in_valid_reg, in_valid_next;
    in_item_t               in_data_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg;
    logic                   advance;
    out_item_t              step_result;
    logic [TIMER_WIDTH-1:0] press_ticks;
    logic [TIMER_WIDTH-1:0] motion_window_ticks;
    logic [TIMER_WIDTH-1:0] settle_ticks;
    logic [TIMER_WIDTH-1:0] stop_timeout_ticks;

    // Step the held transaction whenever the result register is free
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= step_result;
        end
    end

    tci_cfg #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .press_ticks         (press_ticks),
        .motion_window_ticks (motion_window_ticks),
        .settle_ticks        (settle_ticks),
        .stop_timeout_ticks  (stop_timeout_ticks)
    );

    tci_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step_en             (advance),
        .item                (in_data_reg),
        .press_ticks         (press_ticks),
        .motion_window_ticks (motion_window_ticks),
        .settle_ticks        (settle_ticks),
        .stop_timeout_ticks  (stop_timeout_ticks),
        .result              (step_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
